// File: design/rrfd_pkg.sv
// ----------------------------------------------------------------------------
// rrfd_pkg
// Shared types and constants of the remote receiver frame decoder.
// ----------------------------------------------------------------------------
package rrfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int COUNT_W     = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_W       = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // action codes of a request
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_DECODED   = 3'd0;
    localparam logic [2:0] KIND_INVALID   = 3'd1;
    localparam logic [2:0] KIND_BAD_LEN   = 3'd2;
    localparam logic [2:0] KIND_NOT_FIRED = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;

    // configuration register indexes
    localparam logic CFG_CHANNEL_OFFSET = 1'b0;
    localparam logic CFG_ERROR_LIMIT    = 1'b1;

    localparam logic [CFG_W-1:0] OFFSET_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 11'd700;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  rx_byte;
        logic [15:0] key_mask;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [11:0] right_horizontal;
        logic signed [11:0] right_vertical;
        logic signed [11:0] left_horizontal;
        logic signed [11:0] left_vertical;
        logic signed [15:0] dial;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        buttons;
        logic [15:0]        keys;
    } out_item_t;

    typedef struct packed {
        logic signed [11:0] right_horizontal;
        logic signed [11:0] right_vertical;
        logic signed [11:0] left_horizontal;
        logic signed [11:0] left_vertical;
        logic signed [15:0] dial;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        buttons;
        logic [15:0]        keys;
    } record_t;

    typedef enum logic [1:0] {
        OP_DECODE,
        OP_BAD_LENGTH,
        OP_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                         op;
        logic [FRAME_BYTES-1:0][7:0]     frame;
        logic [15:0]                     key_mask;
    } cmd_t;

endpackage

// File: design/rrfd_front.sv
// ----------------------------------------------------------------------------
// rrfd_front
// Collects frame bytes and turns frame ends and key queries into commands.
// ----------------------------------------------------------------------------
module rrfd_front
    import rrfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     push,
    output cmd_t     push_cmd
);

    logic [COUNT_W-1:0]          byte_count_reg;
    logic [COUNT_W-1:0]          byte_count_next;
    logic [FRAME_BYTES-1:0][7:0] frame_reg;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        push            = 1'b0;
        push_cmd.op     = OP_QUERY;
        push_cmd.frame  = frame_reg;
        push_cmd.key_mask = item.key_mask;
        if (accept)
        begin
            unique case (item.action)
                ACT_BYTE:
                begin
                    // saturate so an overlong frame fails the length check
                    if (byte_count_reg != COUNT_MAX)
                        byte_count_next = byte_count_reg + 1'b1;
                end
                ACT_END:
                begin
                    byte_count_next = '0;
                    push            = 1'b1;
                    push_cmd.op     = (byte_count_reg == COUNT_W'(FRAME_BYTES)) ?
                                      OP_DECODE : OP_BAD_LENGTH;
                end
                ACT_QUERY:
                begin
                    push        = 1'b1;
                    push_cmd.op = OP_QUERY;
                end
                default:
                begin
                    // ignored action: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_count_reg <= '0;
        else
            byte_count_reg <= byte_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.action == ACT_BYTE && byte_count_reg < COUNT_W'(FRAME_BYTES))
            frame_reg[byte_count_reg] <= item.rx_byte;
    end

endmodule

// File: design/rrfd_queue.sv
// ----------------------------------------------------------------------------
// rrfd_queue
// Short command queue between the byte collector and the decoder.
// ----------------------------------------------------------------------------
module rrfd_queue
    import rrfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] ptr);
        if (ptr == AW'(QUEUE_DEPTH - 1))
            return '0;
        return ptr + 1'b1;
    endfunction

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= advance(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= advance(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: design/rrfd_back.sv
// ----------------------------------------------------------------------------
// rrfd_back
// Decodes frames, answers press-once queries and holds the result register.
// ----------------------------------------------------------------------------
module rrfd_back
    import rrfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] channel_offset,
    input  logic [CFG_W-1:0] error_limit,
    input  logic             head_valid,
    input  cmd_t             head,
    output logic             pop,
    output logic             out_valid,
    output out_item_t        out_data,
    input  logic             out_stall
);

    record_t     record_reg;
    record_t     record_next;
    logic [15:0] key_changes_reg;
    logic [15:0] key_changes_next;
    logic [15:0] consumed_reg;
    logic [15:0] consumed_next;
    logic        out_valid_reg;
    out_item_t   out_reg;
    out_item_t   out_next;

    logic [FRAME_BYTES-1:0][7:0] b;
    logic [3:0][10:0]            raw;
    logic [3:0][11:0]            stick;
    logic [3:0][10:0]            magnitude;
    logic                        bad;
    logic [1:0]                  sw0;
    logic [1:0]                  sw1;
    record_t                     fresh;

    assign b      = head.frame;
    assign raw[0] = {b[1][2:0], b[0]};
    assign raw[1] = {b[2][5:0], b[1][7:3]};
    assign raw[2] = {b[4][0], b[3], b[2][7:6]};
    assign raw[3] = {b[5][3:0], b[4][7:1]};
    assign sw0    = b[5][5:4];
    assign sw1    = b[5][7:6];

    always_comb
    begin
        bad = (sw0 == 2'd0) || (sw1 == 2'd0);
        for (int i = 0; i < 4; i++)
        begin
            stick[i]     = {1'b0, raw[i]} - {1'b0, channel_offset};
            magnitude[i] = stick[i][11] ? CFG_W'(-stick[i]) : stick[i][10:0];
            if (magnitude[i] > error_limit)
                bad = 1'b1;
        end
        fresh.right_horizontal = stick[0];
        fresh.right_vertical   = stick[1];
        fresh.left_horizontal  = stick[2];
        fresh.left_vertical    = stick[3];
        fresh.dial             = {b[17], b[16]} - {5'd0, channel_offset};
        fresh.switches         = {sw1, sw0};
        fresh.mouse_x          = 16'd0 - {b[9], b[8]};
        fresh.mouse_y          = 16'd0 - {b[7], b[6]};
        fresh.mouse_z          = {b[11], b[10]};
        fresh.buttons          = {b[13], b[12]};
        fresh.keys             = {b[15], b[14]};
    end

    // advance when the result register is free or being taken
    assign pop       = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        record_next      = record_reg;
        key_changes_next = key_changes_reg;
        consumed_next    = consumed_reg;
        out_next         = '0;
        unique case (head.op)
            OP_DECODE:
            begin
                key_changes_next = fresh.keys ^ record_reg.keys;
                if (bad)
                begin
                    record_next   = '0;
                    out_next.kind = KIND_INVALID;
                end
                else
                begin
                    record_next               = fresh;
                    out_next.kind             = KIND_DECODED;
                    out_next.right_horizontal = fresh.right_horizontal;
                    out_next.right_vertical   = fresh.right_vertical;
                    out_next.left_horizontal  = fresh.left_horizontal;
                    out_next.left_vertical    = fresh.left_vertical;
                    out_next.dial             = fresh.dial;
                    out_next.switches         = fresh.switches;
                    out_next.mouse_x          = fresh.mouse_x;
                    out_next.mouse_y          = fresh.mouse_y;
                    out_next.mouse_z          = fresh.mouse_z;
                    out_next.buttons          = fresh.buttons;
                    out_next.keys             = fresh.keys;
                end
            end
            OP_BAD_LENGTH:
            begin
                out_next.kind = KIND_BAD_LEN;
            end
            OP_QUERY:
            begin
                out_next.kind = KIND_NOT_FIRED;
                // released keys re-arm; a fresh press fires once
                if ((record_reg.keys & head.key_mask) == 16'd0)
                    consumed_next = consumed_reg & ~head.key_mask;
                else if ((key_changes_reg & head.key_mask) != 16'd0 &&
                         (consumed_reg & head.key_mask) == 16'd0)
                begin
                    consumed_next = consumed_reg | head.key_mask;
                    out_next.kind = KIND_FIRED;
                end
            end
            default:
            begin
                out_next.kind = KIND_BAD_LEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_reg      <= '0;
            key_changes_reg <= '0;
            consumed_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                record_reg      <= record_next;
                key_changes_reg <= key_changes_next;
                consumed_reg    <= consumed_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

endmodule

// File: design/remote_receiver_frame_decoder.sv
// ----------------------------------------------------------------------------
// remote_receiver_frame_decoder
// Radio-remote frame collector, decoder and press-once key tracker.
// ----------------------------------------------------------------------------
// The block takes one request per clock while in_stall is low. Byte requests
// are stored in the frame buffer the same cycle; frame-end and key-query
// requests enter a two-entry command queue and leave it through the decoder
// into the result register. in_stall rises only while the command queue is
// full, which happens when out_stall holds a result in the result register
// while two more result-producing requests queue behind it, so three results
// are then waiting inside the block.
// Configuration takes effect on the next command to leave the queue.
// ----------------------------------------------------------------------------
module remote_receiver_frame_decoder
    import rrfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] limit_reg;
    logic             accept;
    logic             push;
    cmd_t             push_cmd;
    logic             pop;
    logic             full;
    logic             head_valid;
    cmd_t             head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_OFFSET: offset_reg <= cfg_data;
                CFG_ERROR_LIMIT:    limit_reg  <= cfg_data;
                default:            offset_reg <= offset_reg;
            endcase
        end
    end

    rrfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (in_data),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rrfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    rrfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .channel_offset (offset_reg),
        .error_limit    (limit_reg),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_data       (out_data),
        .out_stall      (out_stall)
    );

endmodule
